FILE: hdl/kvc_pkg.sv
package kvc_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int NUM_VIEWS    = 3;
    localparam int TIMER_BITS   = 16;
    localparam int LEVEL_W      = 7;
    localparam int DELTA_W      = 5;
    localparam int VIEW_W       = 2;
    localparam int SEL_W        = $clog2(NUM_CHANNELS);
    localparam int CFG_DATA_W   = 16;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(100);

    localparam logic [TIMER_BITS-1:0] DEBOUNCE_RESET   = TIMER_BITS'(30);
    localparam logic [TIMER_BITS-1:0] LONG_PRESS_RESET = TIMER_BITS'(600);
    localparam logic [LEVEL_W-1:0]    MASTER_STEP_RESET  = LEVEL_W'(5);
    localparam logic [LEVEL_W-1:0]    CHANNEL_STEP_RESET = LEVEL_W'(3);

    localparam logic [VIEW_W-1:0] VIEW_MASTER   = VIEW_W'(0);
    localparam logic [VIEW_W-1:0] VIEW_CHANNELS = VIEW_W'(1);
    localparam logic [VIEW_W-1:0] VIEW_LAST     = VIEW_W'(NUM_VIEWS - 1);

    typedef enum logic [1:0] {
        REG_DEBOUNCE     = 2'd0,
        REG_LONG_PRESS   = 2'd1,
        REG_MASTER_STEP  = 2'd2,
        REG_CHANNEL_STEP = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [VIEW_W-1:0]         view;
        logic signed [DELTA_W-1:0] delta;
        logic                      short_ev;
        logic                      long_ev;
        logic                      held;
    } cmd_t;

    function automatic logic [LEVEL_W-1:0] level_reset(input logic [SEL_W-1:0] idx);
        logic [LEVEL_W-1:0] v;
        case (idx)
            SEL_W'(0): v = LEVEL_W'(100);
            SEL_W'(1): v = LEVEL_W'(75);
            SEL_W'(2): v = LEVEL_W'(80);
            SEL_W'(3): v = LEVEL_W'(60);
            default:   v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [LEVEL_W-1:0] toggle_mute(input logic [LEVEL_W-1:0] v);
        return (v == '0) ? FULL_LEVEL : '0;
    endfunction

    function automatic logic [LEVEL_W-1:0] adjust_level(
        input logic [LEVEL_W-1:0]        v,
        input logic signed [DELTA_W-1:0] d,
        input logic [LEVEL_W-1:0]        st
    );
        logic signed [14:0] ve;
        logic signed [14:0] de;
        logic signed [14:0] se;
        logic signed [14:0] r;
        logic [LEVEL_W-1:0] res;
        ve = 15'($signed({1'b0, v}));
        de = 15'(d);
        se = 15'($signed({1'b0, st}));
        r  = ve + de * se;
        if (r < 0)
        begin
            res = '0;
        end
        else if (r > 15'($signed({1'b0, FULL_LEVEL})))
        begin
            res = FULL_LEVEL;
        end
        else
        begin
            res = r[LEVEL_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: hdl/knob_volume_controller_unit.sv
// Knob volume controller. Each input item is one millisecond tick with the raw
// button level and the signed encoder count change. Each item yields exactly one
// result with the view, master level, selected channel and its level, the short
// and long press flags and the debounced button state. One item is taken per
// clock cycle sustained while the output is not stalled. The button logic
// classifies the item into a two-entry command queue in the same cycle it is
// taken, and the registered level update stage loads the result as that entry is
// popped. A stalled output holds the result, fills the queue and then drops
// s_tready. Configuration writes take effect at once; the user must make them
// only while no item is in flight, as the block does not enforce this.
module knob_volume_controller_unit
    import kvc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // raw_pressed[0], rotation_delta[5:1], zero fill [7:6]
    input  logic [7:0]            s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // view[1:0], master_level[8:2], selected_channel[10:9], selected_level[17:11],
    // short_event[18], long_event[19], button_held[20], zero fill [23:21]
    output logic [23:0]           m_tdata,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [TIMER_BITS-1:0] debounce_reg;
    logic [TIMER_BITS-1:0] long_press_reg;
    logic [LEVEL_W-1:0]    master_step_reg;
    logic [LEVEL_W-1:0]    channel_step_reg;

    logic               s_accept;
    cmd_t               front_cmd;
    cmd_t               q_cmd;
    logic               q_not_full;
    logic               q_valid;
    logic               q_pop;

    logic [VIEW_W-1:0]  view;
    logic [LEVEL_W-1:0] master_level;
    logic [SEL_W-1:0]   selected_channel;
    logic [LEVEL_W-1:0] selected_level;
    logic               short_event;
    logic               long_event;
    logic               button_held;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg     <= DEBOUNCE_RESET;
            long_press_reg   <= LONG_PRESS_RESET;
            master_step_reg  <= MASTER_STEP_RESET;
            channel_step_reg <= CHANNEL_STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DEBOUNCE:     debounce_reg     <= cfg_data[TIMER_BITS-1:0];
                REG_LONG_PRESS:   long_press_reg   <= cfg_data[TIMER_BITS-1:0];
                REG_MASTER_STEP:  master_step_reg  <= cfg_data[LEVEL_W-1:0];
                REG_CHANNEL_STEP: channel_step_reg <= cfg_data[LEVEL_W-1:0];
                default:          ;
            endcase
        end
    end

    assign s_tready = q_not_full;
    assign s_accept = s_tvalid && s_tready;

    kvc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (s_accept),
        .raw_pressed      (s_tdata[0]),
        .rotation_delta   ($signed(s_tdata[5:1])),
        .debounce_ticks   (debounce_reg),
        .long_press_ticks (long_press_reg),
        .cmd              (front_cmd)
    );

    kvc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_accept),
        .push_data (front_cmd),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_cmd)
    );

    kvc_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_data           (q_cmd),
        .pop              (q_pop),
        .master_step      (master_step_reg),
        .channel_step     (channel_step_reg),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .view             (view),
        .master_level     (master_level),
        .selected_channel (selected_channel),
        .selected_level   (selected_level),
        .short_event      (short_event),
        .long_event       (long_event),
        .button_held      (button_held)
    );

    assign m_tdata = {3'b000, button_held, long_event, short_event, selected_level,
                      selected_channel, master_level, view};

endmodule

FILE: hdl/kvc_front.sv
module kvc_front
    import kvc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         raw_pressed,
    input  logic signed [DELTA_W-1:0]    rotation_delta,
    input  logic [TIMER_BITS-1:0]        debounce_ticks,
    input  logic [TIMER_BITS-1:0]        long_press_ticks,
    output cmd_t                         cmd
);

    logic                  last_raw_reg,  last_raw_next;
    logic [TIMER_BITS-1:0] stable_reg,    stable_next;
    logic [TIMER_BITS-1:0] press_reg,     press_next;
    logic                  held_reg,      held_next;
    logic                  long_seen_reg, long_seen_next;
    logic [VIEW_W-1:0]     view_reg,      view_next;
    logic                  short_ev;
    logic                  long_ev;

    always_comb
    begin
        last_raw_next  = last_raw_reg;
        stable_next    = stable_reg;
        press_next     = press_reg;
        held_next      = held_reg;
        long_seen_next = long_seen_reg;
        view_next      = view_reg;
        short_ev       = 1'b0;
        long_ev        = 1'b0;

        if (raw_pressed != last_raw_reg)
        begin
            last_raw_next = raw_pressed;
            stable_next   = '0;
        end
        else if (stable_reg != '1)
        begin
            stable_next = stable_reg + 1'b1;
        end

        if (held_reg && press_reg != '1)
        begin
            press_next = press_reg + 1'b1;
        end

        if (stable_next > debounce_ticks)
        begin
            if (raw_pressed && !held_reg)
            begin
                held_next      = 1'b1;
                press_next     = '0;
                long_seen_next = 1'b0;
            end
            else if (!raw_pressed && held_reg)
            begin
                if (!long_seen_reg && press_next < long_press_ticks)
                begin
                    short_ev = 1'b1;
                end
                held_next      = 1'b0;
                long_seen_next = 1'b0;
            end
        end

        if (held_next && !long_seen_next && press_next > long_press_ticks)
        begin
            long_seen_next = 1'b1;
            long_ev        = 1'b1;
            view_next      = (view_reg == VIEW_LAST) ? '0 : view_reg + 1'b1;
        end

        cmd.view     = view_next;
        cmd.delta    = rotation_delta;
        cmd.short_ev = short_ev;
        cmd.long_ev  = long_ev;
        cmd.held     = held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg  <= 1'b0;
            stable_reg    <= '0;
            press_reg     <= '0;
            held_reg      <= 1'b0;
            long_seen_reg <= 1'b0;
            view_reg      <= '0;
        end
        else if (accept)
        begin
            last_raw_reg  <= last_raw_next;
            stable_reg    <= stable_next;
            press_reg     <= press_next;
            held_reg      <= held_next;
            long_seen_reg <= long_seen_next;
            view_reg      <= view_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.long_ev) |=> (long_seen_reg && held_reg))
        else $error("long press not latched");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.short_ev) |=> (!held_reg && $past(held_reg)))
        else $error("short press without release");
`endif

endmodule

FILE: hdl/kvc_queue.sv
module kvc_queue
    import kvc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic not_full,
    input  logic pop,
    output logic not_empty,
    output cmd_t pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;

    assign not_full  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !not_full && !pop) |=> (count_reg == CNT_W'(QUEUE_DEPTH)))
        else $error("queue overflow");
`endif

endmodule

FILE: hdl/kvc_back.sv
module kvc_back
    import kvc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  cmd_t                 q_data,
    output logic                 pop,
    input  logic [LEVEL_W-1:0]   master_step,
    input  logic [LEVEL_W-1:0]   channel_step,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [VIEW_W-1:0]    view,
    output logic [LEVEL_W-1:0]   master_level,
    output logic [SEL_W-1:0]     selected_channel,
    output logic [LEVEL_W-1:0]   selected_level,
    output logic                 short_event,
    output logic                 long_event,
    output logic                 button_held
);

    localparam logic [SEL_W-1:0] SPAN = SEL_W'(NUM_CHANNELS - 1);

    logic [LEVEL_W-1:0] levels_reg [1:NUM_CHANNELS-1];
    logic [LEVEL_W-1:0] master_reg, master_next;
    logic [LEVEL_W-1:0] cache_reg,  cache_next;
    logic [SEL_W-1:0]   sel_reg,    sel_next;
    logic               wb_en;
    logic [LEVEL_W-1:0] wb_data;
    logic [LEVEL_W-1:0] master_t;
    logic [LEVEL_W-1:0] cache_t;
    logic [SEL_W-1:0]   sel_step;

    logic               valid_reg;
    logic [VIEW_W-1:0]  view_reg;
    logic               short_reg;
    logic               long_reg;
    logic               held_reg;

    assign pop = q_valid && (!valid_reg || out_ready);

    always_comb
    begin
        master_t = (q_data.short_ev && q_data.view == VIEW_MASTER)
                   ? toggle_mute(master_reg) : master_reg;
        cache_t  = (q_data.short_ev && q_data.view == VIEW_CHANNELS)
                   ? toggle_mute(cache_reg) : cache_reg;

        if (q_data.delta > 0)
        begin
            sel_step = (sel_reg == SPAN) ? SEL_W'(1) : sel_reg + 1'b1;
        end
        else
        begin
            sel_step = (sel_reg == SEL_W'(1)) ? SPAN : sel_reg - 1'b1;
        end

        master_next = master_t;
        cache_next  = cache_t;
        sel_next    = sel_reg;
        wb_en       = 1'b0;
        wb_data     = cache_t;

        if (q_data.delta != '0)
        begin
            if (q_data.view == VIEW_MASTER)
            begin
                master_next = adjust_level(master_t, q_data.delta, master_step);
            end
            else if (q_data.view == VIEW_CHANNELS)
            begin
                sel_next = sel_step;
                if (sel_step != sel_reg)
                begin
                    wb_en      = 1'b1;
                    cache_next = adjust_level(levels_reg[sel_step], q_data.delta,
                                              channel_step);
                end
                else
                begin
                    cache_next = adjust_level(cache_t, q_data.delta, channel_step);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i < NUM_CHANNELS; i++)
            begin
                levels_reg[i] <= level_reset(SEL_W'(i));
            end
            master_reg <= level_reset('0);
            cache_reg  <= level_reset(SEL_W'(1));
            sel_reg    <= SEL_W'(1);
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                master_reg <= master_next;
                cache_reg  <= cache_next;
                sel_reg    <= sel_next;
                if (wb_en)
                begin
                    levels_reg[sel_reg] <= wb_data;
                end
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            view_reg  <= q_data.view;
            short_reg <= q_data.short_ev;
            long_reg  <= q_data.long_ev;
            held_reg  <= q_data.held;
        end
    end

    assign out_valid        = valid_reg;
    assign view             = view_reg;
    assign master_level     = master_reg;
    assign selected_channel = sel_reg;
    assign selected_level   = cache_reg;
    assign short_event      = short_reg;
    assign long_event       = long_reg;
    assign button_held      = held_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (master_reg <= FULL_LEVEL) && (cache_reg <= FULL_LEVEL))
        else $error("level above full scale");

    assert property (@(posedge clk) disable iff (!rst_n)
        (sel_reg != '0) && (sel_reg <= SPAN))
        else $error("selection out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> ($stable(master_reg) && $stable(cache_reg)))
        else $error("held result changed");
`endif

endmodule
